// ----- hw/rtl/stip_pkg.sv -----
// Shared types and character constants for the string-to-integer parser.
`default_nettype none

package stip_pkg;

  localparam int VALUE_W = 64;
  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0] BASE_AUTO  = 5'd0;
  localparam logic [BASE_W-1:0] BASE_OCT   = 5'd8;
  localparam logic [BASE_W-1:0] BASE_DEC   = 5'd10;
  localparam logic [BASE_W-1:0] BASE_HEX   = 5'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_BLANK  = 5'b00001,
    PH_PREFIX = 5'b00010,
    PH_ZERO   = 5'b00100,
    PH_DIGITS = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

  // Parse state kept between characters; value already carries the sign
  typedef struct packed {
    phase_t              phase;
    logic [BASE_W-1:0]   base;
    logic                neg;
    logic [VALUE_W-1:0]  value;
  } state_t;

  // Decoded character
  typedef struct packed {
    logic               blank;
    logic               minus;
    logic               plus;
    logic               zero;
    logic               x_mark;
    logic               dig_ok;
    logic [DIGIT_W-1:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

// ----- hw/rtl/stip_char_class.sv -----
// Character decoder: whitespace, sign, prefix and digit value.
`default_nettype none

module stip_char_class
  import stip_pkg::*;
(
  input  wire logic [7:0] ch,
  output char_class_t     cls
);

  // Classify one byte
  always_comb begin
    cls        = '0;
    cls.blank  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_NL) || (ch == CH_CR);
    cls.minus  = (ch == CH_MINUS);
    cls.plus   = (ch == CH_PLUS);
    cls.zero   = (ch == CH_0);
    cls.x_mark = (ch == CH_LX) || (ch == CH_UX);
    if (ch inside {[CH_0:CH_9]}) begin
      cls.dig_ok = 1'b1;
      cls.digit  = DIGIT_W'(ch - CH_0);
    end else if (ch inside {[CH_LA:CH_LF]}) begin
      cls.dig_ok = 1'b1;
      cls.digit  = DIGIT_W'(ch - CH_LA + 8'd10);
    end else if (ch inside {[CH_UA:CH_UF]}) begin
      cls.dig_ok = 1'b1;
      cls.digit  = DIGIT_W'(ch - CH_UA + 8'd10);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/stip_step.sv -----
// Next-state logic for one character: phase walk and signed multiply-add.
`default_nettype none

module stip_step
  import stip_pkg::*;
(
  input  wire logic              start,
  input  wire logic [BASE_W-1:0] base_select,
  input  wire state_t            st,
  input  wire char_class_t       cls,
  output state_t                 st_nxt,
  output logic                   inc
);

  state_t             cur;
  logic               pre;
  logic               take;
  logic [VALUE_W-1:0] prod;
  logic [VALUE_W-1:0] dig_ext;
  logic [VALUE_W-1:0] addend;

  always_comb begin
    // Restart the parse on a new string
    cur = st;
    if (start) begin
      cur.phase = PH_BLANK;
      cur.base  = base_select;
      cur.neg   = 1'b0;
      cur.value = '0;
    end

    st_nxt = cur;
    inc    = 1'b0;
    pre    = 1'b0;
    take   = 1'b0;

    // Advance through blanks, sign and prefix
    case (cur.phase)
      PH_BLANK: begin
        if (cls.blank) begin
          inc = 1'b1;
        end else if (cls.minus) begin
          st_nxt.neg   = 1'b1;
          st_nxt.phase = PH_PREFIX;
          inc          = 1'b1;
        end else if (cls.plus) begin
          st_nxt.phase = PH_PREFIX;
          inc          = 1'b1;
        end else begin
          pre = 1'b1;
        end
      end
      PH_PREFIX: begin
        pre = 1'b1;
      end
      PH_ZERO: begin
        if (cls.x_mark) begin
          st_nxt.base  = BASE_HEX;
          st_nxt.phase = PH_DIGITS;
          inc          = 1'b1;
        end else begin
          if (cur.base == BASE_AUTO) begin
            st_nxt.base = BASE_OCT;
          end
          st_nxt.phase = PH_DIGITS;
          take         = 1'b1;
        end
      end
      PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
      end
    endcase

    // First character after blanks and sign: leading zero or first digit
    if (pre) begin
      if (((cur.base == BASE_AUTO) || (cur.base == BASE_HEX)) && cls.zero) begin
        st_nxt.phase = PH_ZERO;
        inc          = 1'b1;
      end else begin
        if (cur.base == BASE_AUTO) begin
          st_nxt.base = BASE_DEC;
        end
        st_nxt.phase = PH_DIGITS;
        take         = 1'b1;
      end
    end

    // Shift-and-add product of the value and the 5-bit base
    prod = '0;
    for (int i = 0; i < BASE_W; i++) begin
      if (st_nxt.base[i]) begin
        prod = prod + (cur.value << i);
      end
    end
    dig_ext = VALUE_W'(cls.digit);
    addend  = cur.neg ? ('0 - dig_ext) : dig_ext;

    // Accumulate a digit below the base, otherwise stop
    if (take) begin
      if (cls.dig_ok && ({1'b0, cls.digit} < st_nxt.base)) begin
        st_nxt.value = prod + addend;
        inc          = 1'b1;
      end else begin
        st_nxt.phase = PH_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/string_to_integer_parser_unit.sv -----
// Top level of the streaming string-to-integer parser.
// Usage:
//   Characters enter on the in_ channel (valid/ready), one per request; set
//   in_start_req on the first character of each string. Every character gives
//   one result request on the out_ channel: out_finished, the signed value so
//   far and the count of consumed characters (saturating).
//   cfg_wr_en/cfg_wr_data write the base register (0 = detect from prefix);
//   the base is latched when a string starts. Write it only while idle.
// Latency and throughput:
//   A result is valid the cycle after its character is accepted. One
//   character per cycle is sustained while out_ready is high; the parse state
//   registers double as the result register, and the per-character
//   multiply-add by the 5-bit base sits in the single stage between them.
// Reset and stall:
//   Reset empties the result slot, returns the parse to blank skipping with
//   base detection, and sets the base register to 10. While out_ready is low
//   a held result blocks in_ready; it rises again as soon as the result is
//   taken, in the same cycle the next character may enter.
`default_nettype none

module string_to_integer_parser_unit
  import stip_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [BASE_W-1:0]      cfg_wr_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_start_req,
  input  wire logic [7:0]             in_character,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_finished,
  output logic signed [VALUE_W-1:0]   out_value,
  output logic [OFFSET_BITS-1:0]      out_end_offset
);

  logic [BASE_W-1:0]      base_sel_r;
  state_t                 st_r;
  state_t                 st_nxt;
  logic [OFFSET_BITS-1:0] consumed_r;
  logic [OFFSET_BITS-1:0] consumed_nxt;
  logic [OFFSET_BITS-1:0] cnt_base;
  logic                   out_valid_r;
  logic                   inc;
  logic                   accept;
  char_class_t            cls;

  // Decode the incoming character
  stip_char_class u_class (
    .ch  (in_character),
    .cls (cls)
  );

  // Compute the next parse state
  stip_step u_step (
    .start       (in_start_req),
    .base_select (base_sel_r),
    .st          (st_r),
    .cls         (cls),
    .st_nxt      (st_nxt),
    .inc         (inc)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Saturating consumed-character count
  always_comb begin
    cnt_base     = in_start_req ? '0 : consumed_r;
    consumed_nxt = cnt_base;
    if (inc && (cnt_base != '1)) begin
      consumed_nxt = cnt_base + OFFSET_BITS'(1);
    end
  end

  // Hold the base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_sel_r <= BASE_RESET;
    end else if (cfg_wr_en) begin
      base_sel_r <= cfg_wr_data;
    end
  end

  // Advance parse state and result slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase  <= PH_BLANK;
      st_r.base   <= BASE_AUTO;
      st_r.neg    <= 1'b0;
      st_r.value  <= '0;
      consumed_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        st_r       <= st_nxt;
        consumed_r <= consumed_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_finished   = (st_r.phase == PH_DONE);
  assign out_value      = $signed(st_r.value);
  assign out_end_offset = consumed_r;

  // A fresh string that opens with a space counts exactly one character
  a_blank_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_start_req && (in_character == CH_SPACE) |=> consumed_r == OFFSET_BITS'(1))
    else $error("blank at string start not counted once");

  // Within one string the offset never falls
  a_offset_mono: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_start_req |=> consumed_r >= $past(consumed_r))
    else $error("offset decreased within a string");

  // A stopped parse keeps its value until the next start
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_start_req && (st_r.phase == PH_DONE) |=> $stable(st_r.value) &&
      (st_r.phase == PH_DONE))
    else $error("finished parse changed");

  // Every accepted character yields a pending result
  a_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted character gave no result");

endmodule

`default_nettype wire
